### design/hbsd_pkg.sv
// ============================================================================
// hbsd_pkg: shared types and constants of the bit-serial Huffman decoder
// Field widths, table sizing, mode codes and the structs that pass between
// the sequencer, the code table and the result stage.
// ============================================================================
`default_nettype none

package hbsd_pkg;

    // Table sizing and code length limit
    localparam int TABLE_SLOTS  = 256;
    localparam int MAX_CODE_LEN = 32;
    localparam int LEN_LIMIT    = (MAX_CODE_LEN > 63) ? 63 : MAX_CODE_LEN;

    // Field widths
    localparam int MODE_W       = 2;
    localparam int SLOT_FIELD_W = 8;
    localparam int SYM_W        = 8;
    localparam int LEN_W        = 6;
    localparam int CODE_W       = 32;
    localparam int BYTE_W       = 8;

    // Derived widths
    localparam int SLOT_W    = $clog2(TABLE_SLOTS);
    localparam int PART_W    = LEN_LIMIT;
    localparam int CMP_W     = (PART_W > CODE_W) ? PART_W : CODE_W;
    localparam int BIT_IDX_W = $clog2(BYTE_W);
    localparam int ENTRY_W   = SYM_W + LEN_W + CODE_W;

    localparam logic [SLOT_FIELD_W:0] SLOT_LIMIT = (SLOT_FIELD_W + 1)'(TABLE_SLOTS);

    // Item modes
    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DECODE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    typedef struct packed {
        logic [SYM_W-1:0]  symbol;
        logic [LEN_W-1:0]  length;
        logic [CODE_W-1:0] code;
    } entry_t;

    // Sequencer to code table: loads, clears and sweep reads
    typedef struct packed {
        logic                    load;
        logic                    clear;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [SYM_W-1:0]        symbol;
        logic [LEN_W-1:0]        length;
        logic [CODE_W-1:0]       code;
        logic                    rd_en;
        logic [SLOT_W-1:0]       rd_addr;
    } tbl_cmd_t;

    // Code table to sequencer: one slot, in the cycle after the read
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } tbl_rsp_t;

    // Sequencer to result stage
    typedef struct packed {
        logic             push;
        logic             flush;
        logic [SYM_W-1:0] symbol;
        logic             code_overflow;
    } emit_req_t;

    // Result stage to sequencer
    typedef struct packed {
        logic ready;
        logic pend_vld;
    } emit_sts_t;

endpackage

`default_nettype wire

### design/hbsd_if.sv
// ============================================================================
// hbsd_if: item and result channels of the bit-serial Huffman decoder
// Valid/ready channels; a beat moves when valid and ready are both high.
// ============================================================================
`default_nettype none

interface hbsd_in_if import hbsd_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [MODE_W-1:0]       mode;
    logic [SLOT_FIELD_W-1:0] entry_slot;
    logic [SYM_W-1:0]        entry_symbol;
    logic [LEN_W-1:0]        entry_length;
    logic [CODE_W-1:0]       entry_code;
    logic [BYTE_W-1:0]       data_byte;

    modport source (
        output valid, mode, entry_slot, entry_symbol, entry_length, entry_code, data_byte,
        input  ready
    );
    modport sink (
        input  valid, mode, entry_slot, entry_symbol, entry_length, entry_code, data_byte,
        output ready
    );
endinterface

interface hbsd_out_if import hbsd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             code_overflow;
    logic             last;

    modport source (
        output valid, symbol, code_overflow, last,
        input  ready
    );
    modport sink (
        input  valid, symbol, code_overflow, last,
        output ready
    );
endinterface

`default_nettype wire

### design/hbsd_ram.sv
// ============================================================================
// hbsd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
`default_nettype none

module hbsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### design/hbsd_table.sv
// ============================================================================
// hbsd_table: code table of the decoder
// Valid bits in flip-flops, symbol, length and code in a RAM; loads check
// the slot and the length, and the sweep reads one slot per cycle.
// ============================================================================
`default_nettype none

module hbsd_table import hbsd_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  tbl_cmd_t cmd,
    output tbl_rsp_t rsp
);

    logic [TABLE_SLOTS-1:0] valid_reg;
    logic                   vbit_reg;
    logic                   write;
    logic                   len_ok;
    logic [SLOT_W-1:0]      wr_idx;
    logic [CODE_W-1:0]      code_mask;
    entry_t                 wr_entry;
    logic [ENTRY_W-1:0]     rd_data;

    always_comb
    begin
        write     = cmd.load && ({1'b0, cmd.slot} < SLOT_LIMIT);
        len_ok    = (cmd.length != '0) && (cmd.length <= LEN_W'(LEN_LIMIT));
        wr_idx    = cmd.slot[SLOT_W-1:0];
        // Bits at or above the code length are not part of the code.
        code_mask = (cmd.length >= LEN_W'(CODE_W)) ? '1 : ~({CODE_W{1'b1}} << cmd.length);
        wr_entry.symbol = cmd.symbol;
        wr_entry.length = cmd.length;
        wr_entry.code   = cmd.code & code_mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vbit_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                valid_reg <= '0;
            end
            else if (write)
            begin
                valid_reg[wr_idx] <= len_ok;
            end
            if (cmd.rd_en)
            begin
                vbit_reg <= valid_reg[cmd.rd_addr];
            end
        end
    end

    hbsd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (write),
        .waddr (wr_idx),
        .wdata (wr_entry),
        .re    (cmd.rd_en),
        .raddr (cmd.rd_addr),
        .rdata (rd_data)
    );

    assign rsp.valid = vbit_reg;
    assign rsp.entry = entry_t'(rd_data);

endmodule

`default_nettype wire

### design/hbsd_emit.sv
// ============================================================================
// hbsd_emit: result stage of the decoder
// Holds one pending result until the next one or the end of the byte shows
// whether it is the last, and an output register towards the result channel.
// ============================================================================
`default_nettype none

module hbsd_emit import hbsd_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  emit_req_t         req,
    output emit_sts_t         sts,
    hbsd_out_if.source        result
);

    logic             pend_vld_reg, pend_vld_next;
    logic [SYM_W-1:0] pend_sym_reg, pend_sym_next;
    logic             pend_ovf_reg, pend_ovf_next;
    logic             out_vld_reg,  out_vld_next;
    logic [SYM_W-1:0] out_sym_reg,  out_sym_next;
    logic             out_ovf_reg,  out_ovf_next;
    logic             out_last_reg, out_last_next;
    logic             out_free;
    logic             ready;

    assign out_free = !out_vld_reg || result.ready;
    assign ready    = !pend_vld_reg || out_free;

    always_comb
    begin
        pend_vld_next = pend_vld_reg;
        pend_sym_next = pend_sym_reg;
        pend_ovf_next = pend_ovf_reg;
        out_vld_next  = out_vld_reg;
        out_sym_next  = out_sym_reg;
        out_ovf_next  = out_ovf_reg;
        out_last_next = out_last_reg;

        if (out_vld_reg && result.ready)
        begin
            out_vld_next = 1'b0;
        end

        if (ready && (req.push || req.flush))
        begin
            // A newer result or the end of the byte releases the pending one.
            if (pend_vld_reg)
            begin
                out_vld_next  = 1'b1;
                out_sym_next  = pend_sym_reg;
                out_ovf_next  = pend_ovf_reg;
                out_last_next = req.flush;
            end
            pend_vld_next = req.push;
            if (req.push)
            begin
                pend_sym_next = req.symbol;
                pend_ovf_next = req.code_overflow;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_vld_reg <= 1'b0;
            pend_sym_reg <= '0;
            pend_ovf_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            out_sym_reg  <= '0;
            out_ovf_reg  <= 1'b0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            pend_vld_reg <= pend_vld_next;
            pend_sym_reg <= pend_sym_next;
            pend_ovf_reg <= pend_ovf_next;
            out_vld_reg  <= out_vld_next;
            out_sym_reg  <= out_sym_next;
            out_ovf_reg  <= out_ovf_next;
            out_last_reg <= out_last_next;
        end
    end

    assign sts.ready            = ready;
    assign sts.pend_vld         = pend_vld_reg;
    assign result.valid         = out_vld_reg;
    assign result.symbol        = out_sym_reg;
    assign result.code_overflow = out_ovf_reg;
    assign result.last          = out_last_reg;

endmodule

`default_nettype wire

### design/hbsd_ctrl.sv
// ============================================================================
// hbsd_ctrl: bit sequencer of the decoder
// Shifts the data byte out one bit per step into the partial code register
// and sweeps the code table for a slot of equal length and code.
// ============================================================================
`default_nettype none

module hbsd_ctrl import hbsd_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    hbsd_in_if.sink   item,
    output tbl_cmd_t  tbl_cmd,
    input  tbl_rsp_t  tbl_rsp,
    output emit_req_t emit_req,
    input  emit_sts_t emit_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BIT,
        S_SCAN,
        S_PUSH,
        S_FLUSH
    } state_t;

    state_t                 state_reg,      state_next;
    logic [BYTE_W-1:0]      byte_reg,       byte_next;
    logic [BIT_IDX_W-1:0]   bits_left_reg,  bits_left_next;
    logic [PART_W-1:0]      partial_reg,    partial_next;
    logic [LEN_W-1:0]       plen_reg,       plen_next;
    logic [SLOT_W-1:0]      scan_idx_reg,   scan_idx_next;
    logic                   issue_done_reg, issue_done_next;
    logic                   chk_reg,        chk_next;
    logic                   chk_last_reg,   chk_last_next;
    logic [SYM_W-1:0]       res_sym_reg,    res_sym_next;
    logic                   res_ovf_reg,    res_ovf_next;

    logic accept;
    logic bit_in;
    logic match;
    logic rd_en;
    logic scan_at_end;
    logic bit_done;

    assign item.ready  = (state_reg == S_IDLE);
    assign accept      = item.valid && item.ready;
    assign bit_in      = byte_reg[BYTE_W-1];
    assign scan_at_end = (scan_idx_reg == SLOT_W'(TABLE_SLOTS - 1));

    assign match = (state_reg == S_SCAN) && chk_reg && tbl_rsp.valid &&
                   (tbl_rsp.entry.length == plen_reg) &&
                   (CMP_W'(tbl_rsp.entry.code) == CMP_W'(partial_reg));

    // The sweep stops at the first hit, so the lowest matching slot wins.
    assign rd_en = (state_reg == S_SCAN) && !issue_done_reg && !match;

    always_comb
    begin
        state_next      = state_reg;
        byte_next       = byte_reg;
        bits_left_next  = bits_left_reg;
        partial_next    = partial_reg;
        plen_next       = plen_reg;
        scan_idx_next   = scan_idx_reg;
        issue_done_next = issue_done_reg;
        res_sym_next    = res_sym_reg;
        res_ovf_next    = res_ovf_reg;
        chk_next        = rd_en;
        chk_last_next   = rd_en && scan_at_end;
        bit_done        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (item.mode)
                        MODE_DECODE:
                        begin
                            byte_next      = item.data_byte;
                            bits_left_next = BIT_IDX_W'(BYTE_W - 1);
                            state_next     = S_BIT;
                        end
                        MODE_CLEAR:
                        begin
                            partial_next = '0;
                            plen_next    = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_BIT:
            begin
                byte_next = {byte_reg[BYTE_W-2:0], 1'b0};
                if (plen_reg >= LEN_W'(LEN_LIMIT))
                begin
                    // Code too long: drop the bit and report an overflow.
                    partial_next = '0;
                    plen_next    = '0;
                    res_sym_next = '0;
                    res_ovf_next = 1'b1;
                    state_next   = S_PUSH;
                end
                else
                begin
                    partial_next    = {partial_reg[PART_W-2:0], bit_in};
                    plen_next       = plen_reg + 1'b1;
                    scan_idx_next   = '0;
                    issue_done_next = 1'b0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (rd_en)
                begin
                    if (scan_at_end)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
                if (match)
                begin
                    partial_next = '0;
                    plen_next    = '0;
                    res_sym_next = tbl_rsp.entry.symbol;
                    res_ovf_next = 1'b0;
                    state_next   = S_PUSH;
                end
                else if (chk_reg && chk_last_reg)
                begin
                    bit_done = 1'b1;
                end
            end
            S_PUSH:
            begin
                if (emit_sts.ready)
                begin
                    bit_done = 1'b1;
                end
            end
            S_FLUSH:
            begin
                if (emit_sts.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (bit_done)
        begin
            if (bits_left_reg == '0)
            begin
                state_next = S_FLUSH;
            end
            else
            begin
                bits_left_next = bits_left_reg - 1'b1;
                state_next     = S_BIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            byte_reg       <= '0;
            bits_left_reg  <= '0;
            partial_reg    <= '0;
            plen_reg       <= '0;
            scan_idx_reg   <= '0;
            issue_done_reg <= 1'b0;
            chk_reg        <= 1'b0;
            chk_last_reg   <= 1'b0;
            res_sym_reg    <= '0;
            res_ovf_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            byte_reg       <= byte_next;
            bits_left_reg  <= bits_left_next;
            partial_reg    <= partial_next;
            plen_reg       <= plen_next;
            scan_idx_reg   <= scan_idx_next;
            issue_done_reg <= issue_done_next;
            chk_reg        <= chk_next;
            chk_last_reg   <= chk_last_next;
            res_sym_reg    <= res_sym_next;
            res_ovf_reg    <= res_ovf_next;
        end
    end

    assign tbl_cmd.load    = accept && (item.mode == MODE_LOAD);
    assign tbl_cmd.clear   = accept && (item.mode == MODE_CLEAR);
    assign tbl_cmd.slot    = item.entry_slot;
    assign tbl_cmd.symbol  = item.entry_symbol;
    assign tbl_cmd.length  = item.entry_length;
    assign tbl_cmd.code    = item.entry_code;
    assign tbl_cmd.rd_en   = rd_en;
    assign tbl_cmd.rd_addr = scan_idx_reg;

    assign emit_req.push          = (state_reg == S_PUSH);
    assign emit_req.flush         = (state_reg == S_FLUSH);
    assign emit_req.symbol        = res_sym_reg;
    assign emit_req.code_overflow = res_ovf_reg;

endmodule

`default_nettype wire

### design/huffman_bit_serial_decoder.sv
// ============================================================================
// huffman_bit_serial_decoder: table-driven Huffman decoder, one bit a step
// Loads a code table, then decodes data bytes bit by bit, most significant
// bit first, emitting one result per decoded symbol or code overflow.
// ============================================================================
//
//  Channel  Role    Beat contents
//  -------  ------  ------------------------------------------------------
//  item     sink    mode, entry_slot, entry_symbol, entry_length,
//                   entry_code, data_byte
//  result   source  symbol, code_overflow, last
//
// A load, clear or unused-mode beat leaves the sequencer idle. A decode beat takes
// each of its eight bits in turn: the bit is shifted into the
// partial code, then the code table is swept through the single read port
// of its RAM, one slot per cycle, which ends at the first hit. A stalled
// result channel holds the sequencer in its push and flush states. Reset
// empties the table at once (valid bits in flip-flops) and clears the
// partial code; no clearing pass is needed.
//
`default_nettype none

module huffman_bit_serial_decoder import hbsd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    hbsd_in_if.sink    item,
    hbsd_out_if.source result
);

    tbl_cmd_t  tbl_cmd;
    tbl_rsp_t  tbl_rsp;
    emit_req_t emit_req;
    emit_sts_t emit_sts;

    // Sequencer: owns the byte shift register, the partial code and the
    // table sweep. It takes a new beat only once the previous byte's last
    // result has left for the output register.
    hbsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .tbl_cmd  (tbl_cmd),
        .tbl_rsp  (tbl_rsp),
        .emit_req (emit_req),
        .emit_sts (emit_sts)
    );

    // Code table: valid flags in flip-flops, entries in RAM.
    hbsd_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (tbl_cmd),
        .rsp   (tbl_rsp)
    );

    // Result stage: one result is held back until it is known whether it is
    // the last of its byte; the output register decouples the result channel
    // from the sequencer.
    hbsd_emit u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (emit_req),
        .sts    (emit_sts),
        .result (result)
    );

    // A new beat is only taken when no result of an earlier byte is held back.
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        item.ready |-> !emit_sts.pend_vld)
        else $error("beat accepted while a result is still pending");

    // A decode beat occupies the sequencer for at least the next cycle.
    a_decode_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && (item.mode == MODE_DECODE)) |=> !item.ready)
        else $error("sequencer ready straight after a decode beat");

    // The table sweep never runs while a beat could load or clear the table.
    a_sweep_excl: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_cmd.rd_en |-> (!item.ready && !tbl_cmd.load && !tbl_cmd.clear))
        else $error("table read overlaps a table write");

    // An overflow result always carries symbol zero.
    a_ovf_symbol: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.code_overflow) |-> (result.symbol == '0))
        else $error("overflow result with non-zero symbol");

endmodule

`default_nettype wire

### verif/tb_huffman_bit_serial_decoder.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_huffman_bit_serial_decoder: self-checking bench of the Huffman decoder
// Loads prefix code tables, feeds packed codeword streams and noise beats,
// predicts every decoded symbol and overflow, and checks each result beat
// field by field under random idling on both channels.
// ============================================================================

module tb_huffman_bit_serial_decoder import hbsd_pkg::*; ();

    localparam int CLK_PERIOD = 10;
    localparam int RESET_CYCLES = 7;
    // Mode 3 has no function; the decoder must swallow it silently.
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    // Worst byte: eight full table sweeps and the steps around them.
    localparam int BYTE_CYCLES = 8 * (TABLE_SLOTS + 3) + 2;
    localparam int DRAIN_CYCLES = BYTE_CYCLES + 64;
    // Cycles with no beat on either channel before the run is abandoned.
    localparam int STALL_LIMIT = 10 * BYTE_CYCLES;
    localparam int TOTAL_BEATS = 410;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [SYM_W-1:0]        symbol;
        logic [LEN_W-1:0]        length;
        logic [CODE_W-1:0]       code;
        logic [BYTE_W-1:0]       data;
    } item_beat_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             code_overflow;
        logic             last;
    } decoded_t;

    logic clk = 1'b0;
    logic rst_n;

    hbsd_in_if  item_if ();
    hbsd_out_if result_if ();

    huffman_bit_serial_decoder DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Testbench state
    // ------------------------------------------------------------------------

    // Beats waiting for the driver, and results the decoder still owes us.
    item_beat_t pending_beats[$];
    decoded_t   expected_symbols[$];

    int  queued_beats = 0;
    int  error_count = 0;
    int  stall_cycles = 0;
    int  in_idle_pct = 9;
    int  out_idle_pct = 9;
    logic item_fire;

    // Our own copy of the code table and the partial code being assembled.
    logic             tbl_valid  [TABLE_SLOTS];
    logic [SYM_W-1:0] tbl_symbol [TABLE_SLOTS];
    logic [LEN_W-1:0] tbl_length [TABLE_SLOTS];
    logic [CODE_W-1:0] tbl_code  [TABLE_SLOTS];
    logic [63:0]      part_bits;
    int               part_len;

    // The codebook currently being fed to the decoder by the stimulus.
    logic [CODE_W-1:0] book_code[$];
    int                book_len[$];

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic void wipe_table();
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            tbl_valid[i]  = 1'b0;
            tbl_symbol[i] = '0;
            tbl_length[i] = '0;
            tbl_code[i]   = '0;
        end
        part_bits = '0;
        part_len  = 0;
    endfunction

    // Apply one accepted item beat to the table copy and queue the symbols
    // (and overflows) that it is bound to produce, in order.
    function automatic void decoder_step(item_beat_t b);
        int        produced;
        logic      bit_in;
        logic [CODE_W-1:0] code;
        decoded_t  res;

        produced = 0;
        case (b.mode)
            MODE_LOAD:
            begin
                if (int'(b.slot) < TABLE_SLOTS)
                begin
                    code = b.code;
                    // Code bits at or above the length are not part of the code.
                    if (b.length < 32)
                        code = code & ((32'd1 << b.length) - 32'd1);
                    tbl_symbol[b.slot] = b.symbol;
                    tbl_length[b.slot] = b.length;
                    tbl_code[b.slot]   = code;
                    tbl_valid[b.slot]  = (b.length != 0) && (int'(b.length) <= LEN_LIMIT);
                end
            end
            MODE_CLEAR:
            begin
                wipe_table();
            end
            MODE_DECODE:
            begin
                for (int k = BYTE_W - 1; k >= 0; k--)
                begin
                    bit_in = b.data[k];
                    if (part_len >= LEN_LIMIT)
                    begin
                        // The bit that finds the partial code full is thrown away.
                        part_bits = '0;
                        part_len  = 0;
                        res = '{symbol: '0, code_overflow: 1'b1, last: 1'b0};
                        expected_symbols.insert(expected_symbols.size(), res);
                        produced++;
                    end
                    else
                    begin
                        part_bits = {part_bits[62:0], bit_in};
                        part_len++;
                        // Lowest matching slot wins when codes are duplicated.
                        for (int i = 0; i < TABLE_SLOTS; i++)
                        begin
                            if (tbl_valid[i] && int'(tbl_length[i]) == part_len &&
                                64'(tbl_code[i]) == part_bits)
                            begin
                                res = '{symbol: tbl_symbol[i], code_overflow: 1'b0,
                                        last: 1'b0};
                                expected_symbols.insert(expected_symbols.size(), res);
                                produced++;
                                part_bits = '0;
                                part_len  = 0;
                                break;
                            end
                        end
                    end
                end
                if (produced > 0)
                    expected_symbols[expected_symbols.size() - 1].last = 1'b1;
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic check_result();
        decoded_t exp_res;

        if (expected_symbols.size() == 0)
        begin
            $error("unexpected result beat: symbol %0d code_overflow %0d last %0d",
                   result_if.symbol, result_if.code_overflow, result_if.last);
            error_count++;
        end
        else
        begin
            exp_res = expected_symbols.pop_front();
            if (result_if.symbol !== exp_res.symbol)
            begin
                $error("symbol: expected %0d, actual %0d", exp_res.symbol, result_if.symbol);
                error_count++;
            end
            if (result_if.code_overflow !== exp_res.code_overflow)
            begin
                $error("code_overflow: expected %0d, actual %0d",
                       exp_res.code_overflow, result_if.code_overflow);
                error_count++;
            end
            if (result_if.last !== exp_res.last)
            begin
                $error("last: expected %0d, actual %0d", exp_res.last, result_if.last);
                error_count++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver, ready generator and monitor
    // ------------------------------------------------------------------------

    // Item beats change on the falling edge; a beat is held until taken.
    always @(negedge clk)
    begin : item_driver
        item_beat_t nxt;

        if (!rst_n)
        begin
            item_if.valid <= 1'b0;
        end
        else if (!item_if.valid || item_fire)
        begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= in_idle_pct)
            begin
                nxt = pending_beats.pop_front();
                item_if.mode         <= nxt.mode;
                item_if.entry_slot   <= nxt.slot;
                item_if.entry_symbol <= nxt.symbol;
                item_if.entry_length <= nxt.length;
                item_if.entry_code   <= nxt.code;
                item_if.data_byte    <= nxt.data;
                item_if.valid        <= 1'b1;
            end
            else
            begin
                item_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin : result_stall
        if (!rst_n)
            result_if.ready <= 1'b0;
        else
            result_if.ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // Both channels are sampled on the rising edge. Input beats are predicted
    // before any result of the same edge is checked.
    always @(posedge clk)
    begin : beat_monitor
        item_beat_t seen;

        if (!rst_n)
        begin
            item_fire    <= 1'b0;
            stall_cycles <= 0;
        end
        else
        begin
            item_fire <= item_if.valid && item_if.ready;
            if (item_if.valid && item_if.ready)
            begin
                seen.mode   = item_if.mode;
                seen.slot   = item_if.entry_slot;
                seen.symbol = item_if.entry_symbol;
                seen.length = item_if.entry_length;
                seen.code   = item_if.entry_code;
                seen.data   = item_if.data_byte;
                decoder_step(seen);
            end
            if (result_if.valid && result_if.ready)
                check_result();
            if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin : watchdog
        wait (stall_cycles >= STALL_LIMIT);
        $display("huffman_bit_serial_decoder: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic queue_beat(logic [MODE_W-1:0] mode, logic [SLOT_FIELD_W-1:0] slot,
                              logic [SYM_W-1:0] symbol, logic [LEN_W-1:0] length,
                              logic [CODE_W-1:0] code, logic [BYTE_W-1:0] data);
        item_beat_t b;

        b = '{mode: mode, slot: slot, symbol: symbol, length: length, code: code,
              data: data};
        pending_beats.insert(pending_beats.size(), b);
        queued_beats++;
    endtask

    // Fields that the mode does not use carry random junk.
    task automatic send_load(int slot, int symbol, int length, logic [CODE_W-1:0] code);
        queue_beat(MODE_LOAD, SLOT_FIELD_W'(slot), SYM_W'(symbol), LEN_W'(length), code,
                   BYTE_W'($urandom));
    endtask

    task automatic send_byte(logic [BYTE_W-1:0] data);
        queue_beat(MODE_DECODE, SLOT_FIELD_W'($urandom), SYM_W'($urandom), LEN_W'($urandom),
                   $urandom, data);
    endtask

    task automatic send_other(logic [MODE_W-1:0] mode);
        queue_beat(mode, SLOT_FIELD_W'($urandom), SYM_W'($urandom), LEN_W'($urandom),
                   $urandom, BYTE_W'($urandom));
    endtask

    // Holds the sender back until every beat is taken and every result is in.
    task automatic wait_for_results();
        while (pending_beats.size() != 0 || item_if.valid)
            @(posedge clk);
        while (expected_symbols.size() != 0)
            @(posedge clk);
    endtask

    // Grows a prefix code by splitting leaves of a binary tree. A chain split
    // always opens the newest all-ones leaf, which yields the longest codes.
    task automatic build_codebook(int leaves, bit chain);
        int pick;
        int len;
        logic [CODE_W-1:0] code;

        book_code = {32'd0, 32'd1};
        book_len  = {1, 1};
        while (book_code.size() < leaves)
        begin
            pick = chain ? book_code.size() - 1 : $urandom_range(book_code.size() - 1);
            if (book_len[pick] >= LEN_LIMIT)
                break;
            code = book_code[pick];
            len  = book_len[pick];
            book_code.delete(pick);
            book_len.delete(pick);
            book_code.insert(book_code.size(), {code[CODE_W-2:0], 1'b0});
            book_len.insert(book_len.size(), len + 1);
            book_code.insert(book_code.size(), {code[CODE_W-2:0], 1'b1});
            book_len.insert(book_len.size(), len + 1);
        end
    endtask

    // Scatters the codebook over random free slots, with junk above each
    // code's length, and now and then a duplicate code under another symbol.
    task automatic load_codebook();
        bit slot_taken [TABLE_SLOTS];
        int slot;
        int pick;
        logic [CODE_W-1:0] code;

        for (int i = 0; i <= book_code.size(); i++)
        begin
            if (i == book_code.size())
            begin
                if ($urandom_range(3) != 0)
                    break;
                pick = $urandom_range(book_code.size() - 1);
            end
            else
            begin
                pick = i;
            end
            do
                slot = $urandom_range(TABLE_SLOTS - 1);
            while (slot_taken[slot]);
            slot_taken[slot] = 1'b1;
            code = book_code[pick];
            if (book_len[pick] < 32)
                code = code | ($urandom << book_len[pick]);
            send_load(slot, $urandom_range(255), book_len[pick], code);
        end
    endtask

    // Packs random codewords into bytes, most significant bit first. The tail
    // of the last codeword is simply dropped, which acts as padding.
    task automatic send_codewords(int nbytes);
        bit stream[$];
        int w;
        logic [BYTE_W-1:0] data;

        while (stream.size() < nbytes * BYTE_W)
        begin
            w = $urandom_range(book_len.size() - 1);
            for (int k = book_len[w] - 1; k >= 0; k--)
                stream.insert(stream.size(), book_code[w][k]);
        end
        for (int n = 0; n < nbytes; n++)
        begin
            data = '0;
            for (int j = 0; j < BYTE_W; j++)
                data = {data[BYTE_W-2:0], stream.pop_front()};
            // A stray byte now and then knocks the stream out of step.
            if ($urandom_range(19) == 0)
                send_byte(BYTE_W'($urandom));
            send_byte(data);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial
    begin : stimulus
        int  phase;
        bit  chain;
        int  leaves;

        rst_n                = 1'b0;
        item_if.valid        = 1'b0;
        item_if.mode         = MODE_LOAD;
        item_if.entry_slot   = '0;
        item_if.entry_symbol = '0;
        item_if.entry_length = '0;
        item_if.entry_code   = '0;
        item_if.data_byte    = '0;
        result_if.ready      = 1'b0;
        wipe_table();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // A single 32-bit code, the longest allowed, matched on its last bit.
        send_load(1, 8'hC3, 32, 32'hDEAD_BEEF);
        send_byte(8'hDE);
        send_byte(8'hAD);
        send_byte(8'hBE);
        send_byte(8'hEF);
        // Thirty-two unmatched bits fill the partial code; the next bit
        // overflows it and is discarded.
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_other(MODE_CLEAR);

        // Small prefix table at the edge slots, with junk above the code
        // lengths, a duplicate of code 111 in a higher and a lower slot, and
        // loads whose lengths make them invalid.
        send_load(0, 8'h41, 1, 32'hFFFF_FFFE);
        send_load(255, 8'hFF, 2, 32'h0000_0002);
        send_load(7, 8'h00, 3, 32'hABCD_0006);
        send_load(200, 8'h33, 3, 32'h0000_0007);
        send_load(9, 8'h99, 3, 32'hFFFF_FFFF);
        send_load(100, 8'h55, 0, 32'h0000_0000);
        send_load(101, 8'h66, 33, 32'h0000_0001);
        send_load(102, 8'h77, 63, 32'hFFFF_FFFF);
        send_other(MODE_SPARE);
        // Eight one-bit codes in a row: the most results a byte can give.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h6D);
        // Reloading a live slot with length 0 takes its code out of the table.
        send_load(7, 8'h12, 0, 32'h0000_0006);
        send_byte(8'hC6);

        wait_for_results();

        // Random phases: mostly a fresh table and a well-formed codeword
        // stream, with noise beats and the odd empty-table phase mixed in.
        phase = 0;
        while (queued_beats < TOTAL_BEATS)
        begin
            // A long stretch in the middle runs with no idling at all.
            in_idle_pct  = (phase >= 5 && phase < 9) ? 0 : 9;
            out_idle_pct = in_idle_pct;

            if ($urandom_range(7) != 0)
                send_other(MODE_CLEAR);

            if ($urandom_range(7) == 0)
            begin
                // Nothing loaded: bytes only pile up until the code overflows.
                send_other(MODE_CLEAR);
                repeat ($urandom_range(4, 6))
                    send_byte(BYTE_W'($urandom));
            end
            else
            begin
                chain = ($urandom_range(4) == 0);
                if (chain)
                    leaves = $urandom_range(1) ? LEN_LIMIT + 1 : $urandom_range(8, LEN_LIMIT);
                else
                    leaves = $urandom_range(2, 12);
                build_codebook(leaves, chain);
                // An incomplete code leaves paths that can only overflow.
                if (!chain && book_code.size() > 2 && $urandom_range(3) == 0)
                begin
                    leaves = $urandom_range(book_code.size() - 1);
                    book_code.delete(leaves);
                    book_len.delete(leaves);
                end
                load_codebook();

                repeat ($urandom_range(2))
                begin
                    case ($urandom_range(3))
                        0: send_load($urandom_range(255), $urandom_range(255),
                                     $urandom_range(63), $urandom);
                        1: send_other(MODE_SPARE);
                        2: send_byte(BYTE_W'($urandom));
                        default: send_load($urandom_range(255), $urandom_range(255),
                                           $urandom_range(1, LEN_LIMIT), $urandom);
                    endcase
                end

                send_codewords(chain ? $urandom_range(4, 16) : $urandom_range(3, 14));
            end

            if ($urandom_range(2) == 0)
                wait_for_results();
            phase++;
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("huffman_bit_serial_decoder: match");
        else
            $display("huffman_bit_serial_decoder: mismatch");
        $finish;
    end

endmodule

### filelist.f
design/hbsd_pkg.sv
design/hbsd_if.sv
design/hbsd_ram.sv
design/hbsd_table.sv
design/hbsd_emit.sv
design/hbsd_ctrl.sv
design/huffman_bit_serial_decoder.sv
verif/tb_huffman_bit_serial_decoder.sv
